@@ sv/assert_macros.svh @@
// Assertion macros shared by the thermostat RTL.
// Every macro samples on the rising edge of clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/thm_pkg.sv @@
// Shared types, constants and helper functions for the thermostat unit.
// Used by thm_ctrl, thm_ascii and thermostat_hysteresis_minmax_unit.
package thm_pkg;

  // Field widths.
  localparam int TEMP_W = 12;
  localparam int HYST_W = 8;
  localparam int CFG_W  = 12;
  localparam int CHAR_W = 8;
  localparam int WHOLE_W = 7;
  localparam int DIGIT_W = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SETPOINT   = 1'b0,
    REG_HYSTERESIS = 1'b1
  } reg_index_t;

  // Reset values.
  localparam logic signed [TEMP_W-1:0] SETPOINT_RESET = 12'sd320;
  localparam logic [HYST_W-1:0]        HYST_RESET     = 8'd16;
  localparam logic signed [TEMP_W-1:0] MAX_RESET      = -12'sd880;
  localparam logic signed [TEMP_W-1:0] MIN_RESET      = 12'sd2000;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [WHOLE_W-1:0] HUNDRED = 7'd100;

  // Tenths digit for each fraction nibble, rounded.
  localparam logic [CHAR_W-1:0] TENTHS_TAB [16] = '{
    8'h30, 8'h31, 8'h31, 8'h32, 8'h33, 8'h33, 8'h34, 8'h34,
    8'h35, 8'h36, 8'h36, 8'h37, 8'h38, 8'h38, 8'h39, 8'h39
  };

  // Control results for one sample.
  typedef struct packed {
    logic                     relay_on;
    logic signed [TEMP_W-1:0] max_temp;
    logic signed [TEMP_W-1:0] min_temp;
    logic                     max_changed;
    logic                     min_changed;
  } ctrl_res_t;

  // Readout characters for one sample.
  typedef struct packed {
    logic [CHAR_W-1:0] lead_char;
    logic [CHAR_W-1:0] tens_char;
    logic [CHAR_W-1:0] ones_char;
    logic [CHAR_W-1:0] tenths_char;
  } chars_t;

  // Quotient by ten through the reciprocal 205/2048, exact for 7-bit values.
  function automatic logic [DIGIT_W-1:0] div10(input logic [WHOLE_W-1:0] w);
    logic [14:0] p;
    begin
      p = 15'(w) * 15'd205;
      div10 = p[14:11];
    end
  endfunction

  // Remainder by ten from the quotient above.
  function automatic logic [DIGIT_W-1:0] mod10(input logic [WHOLE_W-1:0] w);
    logic [WHOLE_W-1:0] r;
    begin
      r = w - 7'(div10(w)) * 7'd10;
      mod10 = r[DIGIT_W-1:0];
    end
  endfunction

endpackage

@@ sv/thm_ctrl.sv @@
// Relay hysteresis and running max/min state for the thermostat unit.
// Depends on thm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module thm_ctrl
  import thm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     upd,
  input  logic signed [TEMP_W-1:0] sample,
  input  logic signed [TEMP_W-1:0] setpoint,
  input  logic [HYST_W-1:0]        hysteresis,
  output ctrl_res_t                res
);

  logic                     relay_state;
  logic signed [TEMP_W-1:0] running_max;
  logic signed [TEMP_W-1:0] running_min;
  logic signed [TEMP_W+1:0] upper;
  logic signed [TEMP_W+1:0] lower;
  logic signed [TEMP_W+1:0] sample_ext;
  logic                     relay_next;

  // Switching limits, widened so that no sum wraps.
  always_comb begin
    sample_ext = (TEMP_W+2)'(sample);
    upper = (TEMP_W+2)'(setpoint) + $signed({6'd0, hysteresis});
    lower = (TEMP_W+2)'(setpoint) - $signed({6'd0, hysteresis});
  end

  // Result for the sample against the present state.
  always_comb begin
    if (sample_ext > upper) begin
      relay_next = 1'b1;
    end else if (sample_ext < lower) begin
      relay_next = 1'b0;
    end else begin
      relay_next = relay_state;
    end
    res.relay_on    = relay_next;
    res.max_changed = sample > running_max;
    res.min_changed = sample < running_min;
    res.max_temp    = res.max_changed ? sample : running_max;
    res.min_temp    = res.min_changed ? sample : running_min;
  end

  // State advances once per sample handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state <= 1'b0;
      running_max <= MAX_RESET;
      running_min <= MIN_RESET;
    end else if (upd) begin
      relay_state <= relay_next;
      running_max <= res.max_temp;
      running_min <= res.min_temp;
    end
  end

  `ASSERT_NEXT(a_max_ge_min, upd, running_max >= running_min, "max fell below min")
  `ASSERT_NEXT(a_relay_on_high, upd && (sample_ext > upper), relay_state,
               "relay not on above upper limit")
  `ASSERT_NEXT(a_relay_off_low, upd && (sample_ext < lower), !relay_state,
               "relay not off below lower limit")

endmodule

@@ sv/thm_ascii.sv @@
// Converts a temperature sample into four ASCII readout characters.
// Depends on thm_pkg for the rounding table and the divide-by-ten helpers.
module thm_ascii
  import thm_pkg::*;
(
  input  logic signed [TEMP_W-1:0] sample,
  output chars_t                   chars
);

  logic [TEMP_W-1:0]  mag;
  logic [WHOLE_W-1:0] whole_raw;
  logic [WHOLE_W-1:0] whole;
  logic               neg;
  logic               hundreds;

  // Magnitude, whole degrees and the hundreds fold for positive samples.
  always_comb begin
    neg       = sample[TEMP_W-1];
    mag       = neg ? (TEMP_W)'(-sample) : sample;
    whole_raw = mag[10:4];
    hundreds  = !neg && (whole_raw >= HUNDRED);
    whole     = hundreds ? whole_raw - HUNDRED : whole_raw;
  end

  // Character assembly.
  always_comb begin
    if (neg) begin
      chars.lead_char = CHAR_MINUS;
    end else if (hundreds) begin
      chars.lead_char = CHAR_ONE;
    end else begin
      chars.lead_char = CHAR_SPACE;
    end
    chars.tens_char   = CHAR_ZERO + 8'(div10(whole));
    chars.ones_char   = CHAR_ZERO + 8'(mod10(whole));
    chars.tenths_char = TENTHS_TAB[mag[3:0]];
  end

endmodule

@@ sv/thermostat_hysteresis_minmax_unit.sv @@
// Top level of the thermostat unit: config registers, input and result registers.
// Depends on thm_pkg, thm_ctrl, thm_ascii and assert_macros.svh.
// An accepted word waits in the input register, passes into the result register
// (m_tvalid high) once the result slot is free, and leaves when m_tready is high.
// One word per cycle while m_tready is high, through one compare and readout pass.
// Reset (rst, synchronous) empties both registers, sets setpoint 320 and hysteresis 16.
`include "assert_macros.svh"

module thermostat_hysteresis_minmax_unit
  import thm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // Input stream; s_tdata: temperature[11:0], zero padding [15:12].
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // Result stream; m_tdata: relay_on[0], max_temp[12:1], min_temp[24:13],
  // max_changed[25], min_changed[26], lead_char[34:27], tens_char[42:35],
  // ones_char[50:43], tenths_char[58:51], zero padding [63:59].
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic signed [TEMP_W-1:0] setpoint;
  logic [HYST_W-1:0]        hysteresis;
  logic                     in_valid;
  logic signed [TEMP_W-1:0] in_temp;
  logic                     out_free;
  logic                     advance;
  ctrl_res_t                ctrl_res;
  chars_t                   chars;
  logic [OUT_TDATA_W-1:0]   m_tdata_next;

  // Configuration registers. Reset also turns the relay off and loads max -880
  // and min 2000 in the control block.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= SETPOINT_RESET;
      hysteresis <= HYST_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SETPOINT:   setpoint   <= $signed(cfg_data);
        REG_HYSTERESIS: hysteresis <= cfg_data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result slot is free.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_temp <= $signed(s_tdata[TEMP_W-1:0]);
    end
  end

  thm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .upd        (advance),
    .sample     (in_temp),
    .setpoint   (setpoint),
    .hysteresis (hysteresis),
    .res        (ctrl_res)
  );

  thm_ascii u_ascii (
    .sample (in_temp),
    .chars  (chars)
  );

  // Result word packing.
  assign m_tdata_next = {5'd0, chars.tenths_char, chars.ones_char, chars.tens_char,
                         chars.lead_char, ctrl_res.min_changed, ctrl_res.max_changed,
                         ctrl_res.min_temp, ctrl_res.max_temp, ctrl_res.relay_on};

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= m_tdata_next;
    end
  end

  `ASSERT_SAME(a_ready_when_free, !m_tvalid, s_tready, "input stalled with result slot empty")
  `ASSERT_NEXT(a_advance_fills, advance, m_tvalid, "advanced word did not reach output")
  `ASSERT_NEXT(a_stall_holds_input, in_valid && !out_free, in_valid,
               "input word lost during stall")

endmodule
